// File: rtl/glucose_trimmed_mean_alarm_assert.svh
// Assertion macros for the glucose trimmed-mean alarm block
`ifndef GLUCOSE_TRIMMED_MEAN_ALARM_ASSERT_SVH
`define GLUCOSE_TRIMMED_MEAN_ALARM_ASSERT_SVH
// Check that cons holds in the same cycle as ante
`define GTMA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Check that cons holds in the cycle after ante
`define GTMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/gtma_pkg.sv
// Shared constants, types and codes of the glucose trimmed-mean alarm block
`default_nettype none

package gtma_pkg;

    // round geometry
    localparam int unsigned SAMPLES  = 15;
    localparam int unsigned TRIM     = 3;
    localparam int unsigned EFF_TRIM = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
    localparam int unsigned KEPT     = SAMPLES - 2 * EFF_TRIM;
    localparam int unsigned COUNT_W  = $clog2(SAMPLES + 1);
    localparam int unsigned KCNT_W   = $clog2(KEPT + 1);

    // field widths
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned RAW_W      = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MARGIN_W   = 7;
    localparam int unsigned MARGIN_MAX = 127;

    // mean: sum of kept samples divided by KEPT through a reciprocal multiply
    localparam int unsigned SUM_W      = SAMPLE_W + $clog2(KEPT);
    localparam int unsigned DIV_SHIFT  = SUM_W + $clog2(KEPT);
    localparam int unsigned DIV_MULT_W = SUM_W + 1;
    localparam int unsigned DIV_MULT   = (2 ** DIV_SHIFT + KEPT - 1) / KEPT;
    localparam int unsigned PROD_W     = SUM_W + DIV_MULT_W;

    // calibration: raw * slope / 1000, only the unsaturated range is divided
    localparam int unsigned CAL_P_W     = RAW_W + CFG_DATA_W;
    localparam int unsigned CAL_DIV     = 1000;
    localparam int unsigned CAL_Q_W     = SAMPLE_W + 1;
    localparam int unsigned CAL_SAT_P   = (2 ** CAL_Q_W) * CAL_DIV;
    localparam int unsigned CAL_N       = $clog2(CAL_SAT_P);
    localparam int unsigned CAL_SHIFT   = CAL_N + $clog2(CAL_DIV);
    localparam int unsigned CAL_MULT_W  = CAL_N + 1;
    localparam int unsigned CAL_MULT    = (2 ** CAL_SHIFT + CAL_DIV - 1) / CAL_DIV;
    localparam int unsigned CAL_PROD_W  = CAL_N + CAL_MULT_W;
    localparam int unsigned CAL_SUM_W   = CFG_DATA_W + 1;
    localparam int unsigned CAL_SAT_SUM = 2 ** (SAMPLE_W + 1);

    // front to back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SLOPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LO_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HI_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LO_GUARD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HI_GUARD   = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_ERROR    = 2'd0;
    localparam logic [1:0] STATUS_FIRST    = 2'd1;
    localparam logic [1:0] STATUS_AT_ABOVE = 2'd2;
    localparam logic [1:0] STATUS_BELOW    = 2'd3;

    typedef struct packed {
        logic                failed;
        logic [SAMPLE_W-1:0] value;
    } qitem_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lo_limit;
        logic [SAMPLE_W-1:0] hi_limit;
        logic [SAMPLE_W-1:0] lo_guard;
        logic [SAMPLE_W-1:0] hi_guard;
    } thr_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [1:0]          status;
        logic                hi_alert;
        logic                lo_alert;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_MUL,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/gtma_front.sv
// Front part: accepts raw words and calibrates them to saturated half-unit samples
`default_nettype none

module gtma_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gtma_pkg::RAW_W-1:0]          s_raw_sample,
    input  wire logic                                s_read_failed,
    input  wire logic [gtma_pkg::CFG_DATA_W-1:0]     cal_offset,
    input  wire logic [gtma_pkg::CFG_DATA_W-1:0]     cal_slope,
    output logic                                     q_push_valid,
    input  wire logic                                q_push_ready,
    output gtma_pkg::qitem_t                         q_push_item
);

    logic                                  adv;
    logic                                  v1_reg, v2_reg, v3_reg;
    logic                                  f1_reg, f2_reg;
    logic [gtma_pkg::CAL_P_W-1:0]          p1_reg;
    logic [gtma_pkg::CAL_Q_W-1:0]          q2_reg;
    logic                                  big2_reg;
    logic [gtma_pkg::CAL_PROD_W-1:0]       cal_prod;
    logic [gtma_pkg::CAL_SUM_W-1:0]        cal_sum;
    gtma_pkg::qitem_t                      item_next, item_reg;

    // whole pipe moves together; it stalls only when the last stage cannot push
    assign adv     = !v3_reg || q_push_ready;
    assign s_ready = adv;

    assign cal_prod = gtma_pkg::CAL_PROD_W'(p1_reg[gtma_pkg::CAL_N-1:0])
                    * gtma_pkg::CAL_PROD_W'(gtma_pkg::CAL_MULT);
    assign cal_sum  = gtma_pkg::CAL_SUM_W'(cal_offset) + gtma_pkg::CAL_SUM_W'(q2_reg);

    always_comb begin
        item_next.failed = f2_reg;
        if (big2_reg || cal_sum >= gtma_pkg::CAL_SUM_W'(gtma_pkg::CAL_SAT_SUM)) begin
            item_next.value = '1;
        end else begin
            item_next.value = cal_sum[gtma_pkg::SAMPLE_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg   <= gtma_pkg::CAL_P_W'(s_raw_sample) * gtma_pkg::CAL_P_W'(cal_slope);
            f1_reg   <= s_read_failed;
            q2_reg   <= cal_prod[gtma_pkg::CAL_SHIFT +: gtma_pkg::CAL_Q_W];
            big2_reg <= p1_reg >= gtma_pkg::CAL_P_W'(gtma_pkg::CAL_SAT_P);
            f2_reg   <= f1_reg;
            item_reg <= item_next;
        end
    end

    assign q_push_valid = v3_reg;
    assign q_push_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/gtma_queue.sv
// Short queue of calibrated samples between the front and back parts
`default_nettype none

module gtma_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gtma_pkg::qitem_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output gtma_pkg::qitem_t       out_item
);

    gtma_pkg::qitem_t                slot_reg [gtma_pkg::QUEUE_DEPTH];
    logic [gtma_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [gtma_pkg::QCNT_W-1:0]     cnt_reg;
    logic                            push;

    assign in_ready  = cnt_reg < gtma_pkg::QCNT_W'(gtma_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == gtma_pkg::QPTR_W'(gtma_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (out_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == gtma_pkg::QPTR_W'(gtma_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !out_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && out_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gtma_back.sv
// Back part: sorted insertion, trimmed sum, mean and alarm decision
`default_nettype none

module gtma_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire gtma_pkg::qitem_t   q_item,
    output logic                    q_pop,
    input  wire gtma_pkg::thr_cfg_t thr,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gtma_pkg::result_t       m_result
);

    localparam int unsigned SW = gtma_pkg::SAMPLE_W;
    localparam int unsigned MW = gtma_pkg::MARGIN_W;

    function automatic logic [MW-1:0] calc_low_margin(input logic [SW-1:0] level,
                                                      input logic [SW-1:0] alarm,
                                                      input logic [SW-1:0] margin);
        logic [SW:0]   limit_wide;
        logic [SW-1:0] limit;
        logic [SW-1:0] d;
        limit_wide = {1'b0, alarm} + {1'b0, margin};
        limit      = limit_wide[SW] ? '1 : limit_wide[SW-1:0];
        d          = limit - level;
        if (level >= limit) begin
            return '0;
        end else if (d > SW'(gtma_pkg::MARGIN_MAX)) begin
            return MW'(gtma_pkg::MARGIN_MAX);
        end
        return d[MW-1:0];
    endfunction

    function automatic logic [MW-1:0] calc_high_margin(input logic [SW-1:0] level,
                                                       input logic [SW-1:0] alarm,
                                                       input logic [SW-1:0] margin);
        logic [SW-1:0] limit;
        logic [SW-1:0] d;
        limit = (alarm > margin) ? alarm - margin : '0;
        d     = level - limit;
        if (level <= limit) begin
            return '0;
        end else if (d > SW'(gtma_pkg::MARGIN_MAX)) begin
            return MW'(gtma_pkg::MARGIN_MAX);
        end
        return d[MW-1:0];
    endfunction

    gtma_pkg::back_state_t                 state_reg, state_next;
    logic [SW-1:0]                         store_reg [gtma_pkg::SAMPLES];
    logic [SW-1:0]                         ins_val   [gtma_pkg::SAMPLES];
    logic [SW-1:0]                         shift_val [gtma_pkg::SAMPLES];
    logic [gtma_pkg::SAMPLES-1:0]          used, gt;
    logic [gtma_pkg::COUNT_W-1:0]          count_reg;
    logic [gtma_pkg::KCNT_W-1:0]           kcnt_reg;
    logic [gtma_pkg::SUM_W-1:0]            acc_reg;
    logic [gtma_pkg::PROD_W-1:0]           prod_reg;
    logic [SW-1:0]                         initial_reg;
    logic [MW-1:0]                         low_m_reg, high_m_reg;
    logic [MW-1:0]                         low_m_next, high_m_next;
    logic [SW-1:0]                         initial_next;
    logic                                  m_valid_reg;
    gtma_pkg::result_t                     res_reg, res_next;
    logic [SW-1:0]                         level;
    logic [SW:0]                           thr_hi_wide;
    logic [SW-1:0]                         thr_hi, thr_lo;
    logic                                  out_free, last_in;
    logic                                  ins_en, err_en, sum_en, mul_en, emit_en;

    assign out_free = !m_valid_reg || m_ready;
    assign last_in  = count_reg == gtma_pkg::COUNT_W'(gtma_pkg::SAMPLES - 1);

    // one comparator per slot; slots above the new word move up by one
    for (genvar i = 0; i < gtma_pkg::SAMPLES; i++) begin : g_slot
        assign used[i] = gtma_pkg::COUNT_W'(i) < count_reg;
        assign gt[i]   = used[i] && (store_reg[i] > q_item.value);
        if (i == 0) begin : g_first
            assign ins_val[i] = (gt[i] || !used[i]) ? q_item.value : store_reg[i];
        end else begin : g_rest
            assign ins_val[i] = gt[i-1] ? store_reg[i-1]
                              : ((gt[i] || !used[i]) ? q_item.value : store_reg[i]);
        end
        if (i == gtma_pkg::SAMPLES - 1) begin : g_top
            assign shift_val[i] = store_reg[i];
        end else begin : g_low
            assign shift_val[i] = store_reg[i+1];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gtma_pkg::BK_IDLE: begin
                if (ins_en && last_in) begin
                    state_next = gtma_pkg::BK_SUM;
                end
            end
            gtma_pkg::BK_SUM: begin
                if (kcnt_reg == gtma_pkg::KCNT_W'(1)) begin
                    state_next = gtma_pkg::BK_MUL;
                end
            end
            gtma_pkg::BK_MUL:  state_next = gtma_pkg::BK_EMIT;
            gtma_pkg::BK_EMIT: begin
                if (out_free) begin
                    state_next = gtma_pkg::BK_IDLE;
                end
            end
            default: state_next = gtma_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop   = 1'b0;
        ins_en  = 1'b0;
        err_en  = 1'b0;
        sum_en  = 1'b0;
        mul_en  = 1'b0;
        emit_en = 1'b0;
        unique case (state_reg)
            gtma_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_item.failed) begin
                        q_pop  = out_free;
                        err_en = out_free;
                    end else begin
                        q_pop  = 1'b1;
                        ins_en = 1'b1;
                    end
                end
            end
            gtma_pkg::BK_SUM:  sum_en  = 1'b1;
            gtma_pkg::BK_MUL:  mul_en  = 1'b1;
            gtma_pkg::BK_EMIT: emit_en = out_free;
            default: ;
        endcase
    end

    // decision on the finished mean
    assign level       = prod_reg[gtma_pkg::DIV_SHIFT +: SW];
    assign thr_hi_wide = {1'b0, thr.hi_limit} + (SW + 1)'(high_m_reg);
    assign thr_hi      = thr_hi_wide[SW] ? '1 : thr_hi_wide[SW-1:0];
    assign thr_lo      = (thr.lo_limit > SW'(low_m_reg)) ? thr.lo_limit - SW'(low_m_reg) : '0;

    always_comb begin
        initial_next      = initial_reg;
        low_m_next        = low_m_reg;
        high_m_next       = high_m_reg;
        res_next.level    = level;
        res_next.hi_alert = 1'b0;
        res_next.lo_alert = 1'b0;
        if (initial_reg == '0) begin
            initial_next    = level;
            low_m_next      = calc_low_margin(level, thr.lo_limit, thr.lo_guard);
            high_m_next     = calc_high_margin(level, thr.hi_limit, thr.hi_guard);
            res_next.status = gtma_pkg::STATUS_FIRST;
        end else if (level >= initial_reg) begin
            if (low_m_reg != '0) begin
                low_m_next = calc_low_margin(level, thr.lo_limit, thr.lo_guard);
            end
            res_next.status   = gtma_pkg::STATUS_AT_ABOVE;
            res_next.hi_alert = level > thr_hi;
        end else begin
            if (high_m_reg != '0) begin
                high_m_next = calc_high_margin(level, thr.hi_limit, thr.hi_guard);
            end
            res_next.status   = gtma_pkg::STATUS_BELOW;
            res_next.lo_alert = level < thr_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gtma_pkg::BK_IDLE;
            count_reg   <= '0;
            initial_reg <= '0;
            low_m_reg   <= '0;
            high_m_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (err_en) begin
                count_reg <= '0;
            end else if (ins_en) begin
                count_reg <= last_in ? '0 : count_reg + 1'b1;
            end
            if (emit_en) begin
                initial_reg <= initial_next;
                low_m_reg   <= low_m_next;
                high_m_reg  <= high_m_next;
            end
            if (err_en || emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < gtma_pkg::SAMPLES; i++) begin
            if (ins_en) begin
                store_reg[i] <= ins_val[i];
            end else if (sum_en) begin
                store_reg[i] <= shift_val[i];
            end
        end
        if (ins_en) begin
            acc_reg  <= '0;
            kcnt_reg <= gtma_pkg::KCNT_W'(gtma_pkg::KEPT);
        end else if (sum_en) begin
            acc_reg  <= acc_reg + gtma_pkg::SUM_W'(store_reg[gtma_pkg::EFF_TRIM]);
            kcnt_reg <= kcnt_reg - 1'b1;
        end
        if (mul_en) begin
            prod_reg <= gtma_pkg::PROD_W'(acc_reg)
                      * gtma_pkg::PROD_W'(gtma_pkg::DIV_MULT_W'(gtma_pkg::DIV_MULT));
        end
        if (err_en) begin
            res_reg <= '{level: '0, status: gtma_pkg::STATUS_ERROR,
                         hi_alert: 1'b0, lo_alert: 1'b0};
        end else if (emit_en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

endmodule

`default_nettype wire

// File: rtl/glucose_trimmed_mean_alarm.sv
// Top level of the glucose trimmed-mean alarm block: registers, front, queue, back
// Throughput: one sample word per cycle while a round fills and the front does not stall; after
//   the word that closes a round the back part sums, divides and emits before it takes a word.
// Path with the output free: a read error word passes the front pipeline and the queue into the
//   result register; a round result follows its last word after the serial sum and the multiply.
// Reset: synchronous, active low; clears the round, the initial level and both margins.
`default_nettype none
`include "glucose_trimmed_mean_alarm_assert.svh"

module glucose_trimmed_mean_alarm (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // sample words in
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gtma_pkg::RAW_W-1:0]          s_raw_sample,
    input  wire logic                                s_read_failed,
    // result words out
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [gtma_pkg::SAMPLE_W-1:0]            m_level_half,
    output logic [1:0]                               m_status,
    output logic                                     m_hi_alert,
    output logic                                     m_lo_alert,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gtma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gtma_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [gtma_pkg::CFG_DATA_W-1:0] cal_offset_reg, cal_slope_reg;
    logic [gtma_pkg::SAMPLE_W-1:0]   lo_limit_reg, hi_limit_reg;
    logic [gtma_pkg::SAMPLE_W-1:0]   lo_guard_reg, hi_guard_reg;
    gtma_pkg::thr_cfg_t              thr;
    logic                            fq_valid, fq_ready;
    gtma_pkg::qitem_t                fq_item;
    logic                            q_valid, q_pop;
    gtma_pkg::qitem_t                q_item;
    gtma_pkg::result_t               result;

    // Register writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_offset_reg <= '0;
            cal_slope_reg  <= 16'd1000;
            lo_limit_reg   <= 8'd35;
            hi_limit_reg   <= 8'd125;
            lo_guard_reg   <= 8'd5;
            hi_guard_reg   <= 8'd5;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gtma_pkg::REG_CAL_OFFSET: cal_offset_reg <= cfg_data;
                gtma_pkg::REG_CAL_SLOPE:  cal_slope_reg  <= cfg_data;
                gtma_pkg::REG_LO_LIMIT:   lo_limit_reg   <= cfg_data[gtma_pkg::SAMPLE_W-1:0];
                gtma_pkg::REG_HI_LIMIT:   hi_limit_reg   <= cfg_data[gtma_pkg::SAMPLE_W-1:0];
                gtma_pkg::REG_LO_GUARD:   lo_guard_reg   <= cfg_data[gtma_pkg::SAMPLE_W-1:0];
                gtma_pkg::REG_HI_GUARD:   hi_guard_reg   <= cfg_data[gtma_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign thr.lo_limit = lo_limit_reg;
    assign thr.hi_limit = hi_limit_reg;
    assign thr.lo_guard = lo_guard_reg;
    assign thr.hi_guard = hi_guard_reg;

    // Front: multiply, reciprocal divide by 1000, offset and saturate, one word per cycle unless the queue is full.
    gtma_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_sample  (s_raw_sample),
        .s_read_failed (s_read_failed),
        .cal_offset    (cal_offset_reg),
        .cal_slope     (cal_slope_reg),
        .q_push_valid  (fq_valid),
        .q_push_ready  (fq_ready),
        .q_push_item   (fq_item)
    );

    // Queue: lets the front keep calibrating while the back sums a finished round.
    gtma_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // Back: insert into the sorted store, sum the middle slots, divide, decide and hold
    // the result word in its output register.
    gtma_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .thr      (thr),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_level_half = result.level;
    assign m_status     = result.status;
    assign m_hi_alert   = result.hi_alert;
    assign m_lo_alert   = result.lo_alert;

    // A read error word carries level zero and no alarm.
    `GTMA_ASSERT_SAME(a_error_word_clean, aclk, aresetn, m_valid && (m_status == gtma_pkg::STATUS_ERROR), (m_level_half == '0) && !m_hi_alert && !m_lo_alert, "read error word with level or alarm set")
    // The first latched level never raises an alarm.
    `GTMA_ASSERT_SAME(a_first_no_alarm, aclk, aresetn, m_valid && (m_status == gtma_pkg::STATUS_FIRST), !m_hi_alert && !m_lo_alert, "alarm on first level word")
    // A high alarm only comes with a level at or above the initial one.
    `GTMA_ASSERT_SAME(a_high_alarm_status, aclk, aresetn, m_valid && m_hi_alert, m_status == gtma_pkg::STATUS_AT_ABOVE, "high alarm with wrong status")
    // Popping a failed word presents an error result on the next cycle.
    `GTMA_ASSERT_NEXT(a_error_pop_result, aclk, aresetn, q_pop && q_item.failed, m_valid && (m_status == gtma_pkg::STATUS_ERROR), "failed word did not produce an error result")

endmodule

`default_nettype wire

// File: test/glucose_trimmed_mean_alarm_tb.sv
// Self-checking testbench for the glucose trimmed-mean alarm block
`timescale 1ns / 100ps

module glucose_trimmed_mean_alarm_tb;

    // register indexes that the block does not implement; writes to them must be ignored
    localparam logic [gtma_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [gtma_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // cycles to let pass once nothing is due, long enough for a round result to come out
    localparam int SETTLE_CYCLES = 4 * gtma_pkg::KEPT + 12;

    typedef struct {
        logic [gtma_pkg::RAW_W-1:0] raw;
        logic                       failed;
    } sample_word_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [gtma_pkg::RAW_W-1:0]      s_raw_sample = '0;
    logic                            s_read_failed = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [gtma_pkg::SAMPLE_W-1:0]   m_level_half;
    logic [1:0]                      m_status;
    logic                            m_hi_alert;
    logic                            m_lo_alert;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gtma_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gtma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    glucose_trimmed_mean_alarm dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_sample  (s_raw_sample),
        .s_read_failed (s_read_failed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level_half  (m_level_half),
        .m_status      (m_status),
        .m_hi_alert    (m_hi_alert),
        .m_lo_alert    (m_lo_alert),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the registers, updated when a register write is accepted
    logic [15:0] cfg_offset = 16'd0;
    logic [15:0] cfg_slope = 16'd1000;
    logic [7:0]  cfg_lo_limit = 8'd35;
    logic [7:0]  cfg_hi_limit = 8'd125;
    logic [7:0]  cfg_lo_guard = 8'd5;
    logic [7:0]  cfg_hi_guard = 8'd5;

    // Predictor copy of the block state
    logic [gtma_pkg::SAMPLE_W-1:0] round_store [gtma_pkg::SAMPLES];
    int                            fill_count = 0;
    logic [gtma_pkg::SAMPLE_W-1:0] first_level = '0;  // zero: no initial level latched yet
    logic [gtma_pkg::MARGIN_W-1:0] low_slack = '0;
    logic [gtma_pkg::MARGIN_W-1:0] high_slack = '0;

    sample_word_t      sample_backlog [$];   // words waiting for the driver
    gtma_pkg::result_t reports_due [$];      // predicted result words, oldest first
    int                mismatches = 0;

    // Handshake pacing
    int           send_gap = 0;
    bit           send_calm = 1'b0;
    int           hold_left = 0;
    bit           take_calm = 1'b0;
    sample_word_t next_word;

    task automatic flag(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offset + raw * slope / 1000, halved and clipped to one byte
    function automatic logic [gtma_pkg::SAMPLE_W-1:0] calibrate(
            logic [gtma_pkg::RAW_W-1:0] raw);
        longint unsigned scaled;
        scaled = raw;
        scaled = scaled * cfg_slope / gtma_pkg::CAL_DIV;
        scaled = (scaled + cfg_offset) >> 1;
        return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    // Sort a copy of the round, drop the trimmed ends, average the middle
    function automatic logic [gtma_pkg::SAMPLE_W-1:0] trimmed_level();
        logic [gtma_pkg::SAMPLE_W-1:0] v [gtma_pkg::SAMPLES];
        logic [gtma_pkg::SAMPLE_W-1:0] x;
        int                            j;
        int unsigned                   total;
        v = round_store;
        for (int i = 1; i < gtma_pkg::SAMPLES; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        total = 0;
        for (int i = gtma_pkg::EFF_TRIM; i < gtma_pkg::SAMPLES - gtma_pkg::EFF_TRIM; i++)
            total += v[i];
        return 8'(total / gtma_pkg::KEPT);
    endfunction

    function automatic logic [gtma_pkg::MARGIN_W-1:0] low_margin_for(
            logic [gtma_pkg::SAMPLE_W-1:0] lvl);
        int unsigned limit, d;
        limit = cfg_lo_limit + cfg_lo_guard;
        if (limit > 255) limit = 255;
        if (lvl >= limit) return '0;
        d = limit - lvl;
        return (d > gtma_pkg::MARGIN_MAX) ? 7'(gtma_pkg::MARGIN_MAX) : d[6:0];
    endfunction

    function automatic logic [gtma_pkg::MARGIN_W-1:0] high_margin_for(
            logic [gtma_pkg::SAMPLE_W-1:0] lvl);
        int unsigned limit, d;
        limit = (cfg_hi_limit > cfg_hi_guard) ? cfg_hi_limit - cfg_hi_guard : 0;
        if (lvl <= limit) return '0;
        d = lvl - limit;
        return (d > gtma_pkg::MARGIN_MAX) ? 7'(gtma_pkg::MARGIN_MAX) : d[6:0];
    endfunction

    // Advance the predicted state by one accepted word; queue a result when a round ends
    task automatic absorb_sample(logic [gtma_pkg::RAW_W-1:0] raw, logic failed);
        gtma_pkg::result_t r;
        logic [7:0]        lvl;
        int unsigned       thr;
        r = '0;
        if (failed) begin
            fill_count = 0;
            r.status = gtma_pkg::STATUS_ERROR;
            reports_due.push_back(r);
            return;
        end
        round_store[fill_count] = calibrate(raw);
        fill_count++;
        if (fill_count < gtma_pkg::SAMPLES) return;
        fill_count = 0;
        lvl = trimmed_level();
        r.level = lvl;
        if (first_level == 0) begin
            first_level = lvl;
            low_slack = low_margin_for(lvl);
            high_slack = high_margin_for(lvl);
            r.status = gtma_pkg::STATUS_FIRST;
        end else if (lvl >= first_level) begin
            if (low_slack != 0) low_slack = low_margin_for(lvl);
            r.status = gtma_pkg::STATUS_AT_ABOVE;
            thr = cfg_hi_limit + high_slack;
            if (thr > 255) thr = 255;
            r.hi_alert = (lvl > thr);
        end else begin
            if (high_slack != 0) high_slack = high_margin_for(lvl);
            r.status = gtma_pkg::STATUS_BELOW;
            thr = (cfg_lo_limit > low_slack) ? cfg_lo_limit - low_slack : 0;
            r.lo_alert = (lvl < thr);
        end
        reports_due.push_back(r);
    endtask

    task automatic check_result();
        gtma_pkg::result_t want;
        if (reports_due.size() == 0) begin
            flag($sformatf("result word with none due: level %0d status %0d",
                           m_level_half, m_status));
            return;
        end
        want = reports_due.pop_front();
        if (m_level_half !== want.level)
            flag($sformatf("level_half got %0d want %0d", m_level_half, want.level));
        if (m_status !== want.status)
            flag($sformatf("status got %0d want %0d", m_status, want.status));
        if (m_hi_alert !== want.hi_alert)
            flag($sformatf("hi_alert got %0d want %0d", m_hi_alert, want.hi_alert));
        if (m_lo_alert !== want.lo_alert)
            flag($sformatf("lo_alert got %0d want %0d", m_lo_alert, want.lo_alert));
    endtask

    // Sample word driver: predict on acceptance, then load the next word or idle.
    // Hold valid and payload while the block stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_sample(s_raw_sample, s_read_failed);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    next_word = sample_backlog.pop_front();
                    s_raw_sample <= next_word.raw;
                    s_read_failed <= next_word.failed;
                    s_valid <= 1'b1;
                    // switch now and then between paced and back-to-back stretches
                    if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
                    send_gap = send_calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted result word, stall ready at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result();
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!take_calm && $urandom_range(0, 5) == 0) hold_left = pick_gap();
                if ($urandom_range(0, 255) == 0) take_calm = !take_calm;
            end
        end
    end

    // Write one register; update the predictor copy on acceptance, drop unknown indexes
    task automatic write_reg(logic [gtma_pkg::CFG_IDX_W-1:0] idx,
                             logic [gtma_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gtma_pkg::REG_CAL_OFFSET: cfg_offset = data;
            gtma_pkg::REG_CAL_SLOPE:  cfg_slope = data;
            gtma_pkg::REG_LO_LIMIT:   cfg_lo_limit = data[7:0];
            gtma_pkg::REG_HI_LIMIT:   cfg_hi_limit = data[7:0];
            gtma_pkg::REG_LO_GUARD:   cfg_lo_guard = data[7:0];
            gtma_pkg::REG_HI_GUARD:   cfg_hi_guard = data[7:0];
            default: ;
        endcase
    endtask

    // Wait until every word is sent and every result is in, then let a partial round drain
    task automatic drain();
        while (sample_backlog.size() != 0 || s_valid || reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_word(logic [gtma_pkg::RAW_W-1:0] raw, logic failed);
        sample_word_t w;
        w.raw = raw;
        w.failed = failed;
        sample_backlog.push_back(w);
    endtask

    // Random traffic: mostly whole rounds clustered around a level, with trimmed outliers;
    // some rounds broken by a read error, some stray noise words.
    task automatic queue_rounds(int count);
        int pushed, hi, base, spread, abort_at, r, v;
        pushed = 0;
        hi = (cfg_slope == 0) ? 4095 : 512000 / cfg_slope + 1;
        if (hi > 4095) hi = 4095;
        while (pushed < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_word(12'($urandom), 1'($urandom_range(0, 1)));
                pushed++;
            end else begin
                base = $urandom_range(0, hi);
                spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                     : $urandom_range(0, 8);
                abort_at = (r < 20) ? $urandom_range(0, gtma_pkg::SAMPLES - 1) : -1;
                for (int i = 0; i < gtma_pkg::SAMPLES; i++) begin
                    pushed++;
                    if (i == abort_at) begin
                        push_word(12'($urandom), 1'b1);
                        break;
                    end
                    if ($urandom_range(0, 99) < 12) begin
                        v = $urandom_range(0, 4095);
                    end else begin
                        v = base + $urandom_range(0, 2 * spread) - spread;
                        if (v < 0) v = 0;
                        if (v > 4095) v = 4095;
                    end
                    push_word(12'(v), 1'b0);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings. A round of zeros averages to zero and latches nothing,
        // a read error ignores its raw value, and an error mid-round aborts the round.
        for (int i = 0; i < gtma_pkg::SAMPLES; i++) push_word(12'd0, 1'b0);
        push_word(12'hFFF, 1'b1);
        repeat (3) push_word(12'hFFF, 1'b0);
        push_word(12'h5A5, 1'b1);
        queue_rounds(150);
        drain();

        // Top extremes: everything saturates, thresholds at the top, margins masked to a byte
        write_reg(gtma_pkg::REG_CAL_OFFSET, 16'hFFFF);
        write_reg(gtma_pkg::REG_CAL_SLOPE, 16'hFFFF);
        write_reg(gtma_pkg::REG_LO_LIMIT, 16'hFFFF);
        write_reg(gtma_pkg::REG_HI_LIMIT, 16'hFFFF);
        write_reg(gtma_pkg::REG_LO_GUARD, 16'hFFFF);
        write_reg(gtma_pkg::REG_HI_GUARD, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'($urandom));
        queue_rounds(80);
        drain();

        // Bottom extremes: zero slope and offset, every level collapses to zero
        write_reg(gtma_pkg::REG_CAL_OFFSET, 16'h0000);
        write_reg(gtma_pkg::REG_CAL_SLOPE, 16'h0000);
        write_reg(gtma_pkg::REG_LO_LIMIT, 16'h0000);
        write_reg(gtma_pkg::REG_HI_LIMIT, 16'h0000);
        write_reg(gtma_pkg::REG_LO_GUARD, 16'h0000);
        write_reg(gtma_pkg::REG_HI_GUARD, 16'h0000);
        write_reg(REG_SPARE_HI, 16'($urandom));
        queue_rounds(60);
        drain();

        // Random settings, mostly in a range where levels spread over the byte
        for (int p = 0; p < 6; p++) begin
            write_reg(gtma_pkg::REG_CAL_OFFSET,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 120)));
            write_reg(gtma_pkg::REG_CAL_SLOPE,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(300, 3000)));
            write_reg(gtma_pkg::REG_LO_LIMIT, 16'($urandom));
            write_reg(gtma_pkg::REG_HI_LIMIT, 16'($urandom));
            write_reg(gtma_pkg::REG_LO_GUARD,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 60)));
            write_reg(gtma_pkg::REG_HI_GUARD,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 60)));
            if (p[0]) write_reg(REG_SPARE_LO, 16'($urandom));
            queue_rounds(110);
            drain();
        end

        if (mismatches == 0) begin
            $display("glucose_trimmed_mean_alarm_tb OK");
        end else begin
            $display("glucose_trimmed_mean_alarm_tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest passing run
    initial begin
        #5_000_000;
        $display("glucose_trimmed_mean_alarm_tb NOT OK");
        $finish;
    end

endmodule
